// File: src/lnc_pkg.sv
package lnc_pkg;

    // Item kinds carried on the input side.
    typedef logic [1:0] lnc_op_t;
    localparam lnc_op_t OP_CYCLES   = 2'd0;
    localparam lnc_op_t OP_LENGTH   = 2'd1;
    localparam lnc_op_t OP_ENVELOPE = 2'd2;
    localparam lnc_op_t OP_WRITE    = 2'd3;

    // Register selects for a write item.
    typedef logic [1:0] lnc_reg_sel_t;
    localparam lnc_reg_sel_t REG_LENGTH   = 2'd0;
    localparam lnc_reg_sel_t REG_ENVELOPE = 2'd1;
    localparam lnc_reg_sel_t REG_POLY     = 2'd2;
    localparam lnc_reg_sel_t REG_CONTROL  = 2'd3;

    localparam int LFSR_W    = 15;
    localparam int DIV_W     = 20;
    localparam int LEN_W     = 7;
    localparam int VOL_W     = 4;

    localparam logic [LFSR_W-1:0] LFSR_ALL_ONES = 15'h7FFF;
    localparam logic [LEN_W-1:0]  LEN_FULL      = 7'd64;
    localparam logic [VOL_W-1:0]  VOL_MAX       = 4'hF;
    localparam logic [3:0]        SHIFT_LIMIT   = 4'd14;
    localparam int                TRIGGER_BIT   = 7;
    localparam int                LEN_EN_BIT    = 6;

    typedef struct packed {
        lnc_op_t      op;
        logic [3:0]   cycle_count;
        lnc_reg_sel_t reg_sel;
        logic [7:0]   write_data;
    } lnc_item_t;

    typedef struct packed {
        logic [VOL_W-1:0] sample;
        logic             channel_on;
    } lnc_result_t;

    // Base divider period for each divisor code.
    function automatic logic [6:0] divisor_base(input logic [2:0] code);
        logic [6:0] base;
        unique case (code)
            3'd0:    base = 7'd8;
            3'd1:    base = 7'd16;
            3'd2:    base = 7'd32;
            3'd3:    base = 7'd48;
            3'd4:    base = 7'd64;
            3'd5:    base = 7'd80;
            3'd6:    base = 7'd96;
            default: base = 7'd112;
        endcase
        return base;
    endfunction

    // One shift of the noise register; the feedback also lands in bit 6 in short mode.
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] cur,
                                                    input logic short_mode);
        logic              fb;
        logic [LFSR_W-1:0] nxt;
        fb  = cur[0] ^ cur[1];
        nxt = {fb, cur[LFSR_W-1:1]};
        if (short_mode)
        begin
            nxt[6] = fb;
        end
        return nxt;
    endfunction

endpackage

// File: src/lfsr_noise_channel.sv
// Noise voice of a handheld-console sound unit. Each input item is a batch of clock
// cycles, a length clock, an envelope clock or a write to one of the four channel
// registers, and each item yields exactly one result item holding the current 4-bit
// sample and the channel-on flag as they stand after that item. The block takes one
// item per clock as long as the output side keeps taking results: an item is held in
// the input register, its whole state update is computed from there and written
// together with its result into the result register, which drives the output. The
// shift register steps at most twice per cycle batch, and a period shift of 14 or
// more freezes it.
module lfsr_noise_channel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cycle_count [3:0], write_data [11:4], zeros [15:12]
    input  logic [15:0] s_axis_tdata,
    // op [1:0], reg_sel [3:2]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sample [3:0], channel_on [4], zeros [7:5]
    output logic [7:0]  m_axis_tdata
);
    import lnc_pkg::*;

    lnc_item_t   in_item;
    lnc_item_t   item;
    lnc_result_t result;
    lnc_result_t out_result;
    logic        item_valid;
    logic        can_load;
    logic        fire;

    // Unpack the stream fields into one item.
    assign in_item.op          = s_axis_tuser[1:0];
    assign in_item.reg_sel     = s_axis_tuser[3:2];
    assign in_item.cycle_count = s_axis_tdata[3:0];
    assign in_item.write_data  = s_axis_tdata[11:4];

    // An item is processed when it sits in the input register and the result
    // register is free or being emptied in the same cycle.
    assign fire = item_valid && can_load;

    lnc_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (fire),
        .item       (item)
    );

    lnc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    lnc_output_stage u_output (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .can_load   (can_load),
        .result     (result),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {3'b000, out_result.channel_on, out_result.sample};
endmodule

// File: src/lnc_input_stage.sv
module lnc_input_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lnc_pkg::lnc_item_t in_item,
    output logic              item_valid,
    input  logic              item_take,
    output lnc_pkg::lnc_item_t item
);
    import lnc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    lnc_item_t item_reg;

    // The register refills in the same cycle that its item moves on.
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (valid_reg && !item_take) || in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

// File: src/lnc_core.sv
module lnc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  lnc_pkg::lnc_item_t  item,
    output lnc_pkg::lnc_result_t result
);
    import lnc_pkg::*;

    logic [LFSR_W-1:0] lfsr_reg,        lfsr_next;
    logic [DIV_W-1:0]  div_count_reg,   div_count_next;
    logic [2:0]        divisor_reg,     divisor_next;
    logic [3:0]        shift_reg,       shift_next;
    logic              short_reg,       short_next;
    logic [LEN_W-1:0]  length_reg,      length_next;
    logic              len_en_reg,      len_en_next;
    logic [2:0]        env_period_reg,  env_period_next;
    logic [2:0]        env_count_reg,   env_count_next;
    logic              env_up_reg,      env_up_next;
    logic [VOL_W-1:0]  env_start_reg,   env_start_next;
    logic [VOL_W-1:0]  volume_reg,      volume_next;
    logic              env_run_reg,     env_run_next;
    logic              enabled_reg,     enabled_next;

    logic [DIV_W-1:0]   period;
    logic [DIV_W:0]     sum;
    logic [DIV_W:0]     period_x2;
    logic [DIV_W+1:0]   period_x3;
    logic [LFSR_W-1:0]  lfsr_one;
    logic [LFSR_W-1:0]  lfsr_two;
    logic [7:0]         wd;

    // Shift below the limit keeps the period under 2^20.
    assign period    = DIV_W'(divisor_base(divisor_reg)) << shift_reg;
    assign sum       = {1'b0, div_count_reg} + (DIV_W+1)'(item.cycle_count);
    assign period_x2 = {period, 1'b0};
    assign period_x3 = {1'b0, period_x2} + (DIV_W+2)'(period);
    assign lfsr_one  = lfsr_step(lfsr_reg, short_reg);
    assign lfsr_two  = lfsr_step(lfsr_one, short_reg);
    assign wd        = item.write_data;

    always_comb
    begin
        lfsr_next       = lfsr_reg;
        div_count_next  = div_count_reg;
        divisor_next    = divisor_reg;
        shift_next      = shift_reg;
        short_next      = short_reg;
        length_next     = length_reg;
        len_en_next     = len_en_reg;
        env_period_next = env_period_reg;
        env_count_next  = env_count_reg;
        env_up_next     = env_up_reg;
        env_start_next  = env_start_reg;
        volume_next     = volume_reg;
        env_run_next    = env_run_reg;
        enabled_next    = enabled_reg;

        unique case (item.op)
            OP_CYCLES:
            begin
                if (enabled_reg && shift_reg < SHIFT_LIMIT)
                begin
                    // At most two steps; a count still past the period is cleared.
                    priority if ({1'b0, sum} >= period_x3)
                    begin
                        lfsr_next      = lfsr_two;
                        div_count_next = '0;
                    end
                    else if (sum >= period_x2)
                    begin
                        lfsr_next      = lfsr_two;
                        div_count_next = DIV_W'(sum - period_x2);
                    end
                    else if (sum >= {1'b0, period})
                    begin
                        lfsr_next      = lfsr_one;
                        div_count_next = DIV_W'(sum - {1'b0, period});
                    end
                    else
                    begin
                        div_count_next = DIV_W'(sum);
                    end
                end
            end
            OP_LENGTH:
            begin
                if (len_en_reg && length_reg != '0)
                begin
                    length_next = length_reg - 1'b1;
                    if (length_reg == LEN_W'(1))
                    begin
                        enabled_next = 1'b0;
                    end
                end
            end
            OP_ENVELOPE:
            begin
                if (enabled_reg && env_run_reg && env_period_reg != '0)
                begin
                    if (env_count_reg <= 3'd1)
                    begin
                        env_count_next = env_period_reg;
                        if (env_up_reg)
                        begin
                            if (volume_reg != VOL_MAX)
                            begin
                                volume_next = volume_reg + 1'b1;
                                if (volume_reg == VOL_MAX - 1'b1)
                                begin
                                    env_run_next = 1'b0;
                                end
                            end
                        end
                        else if (volume_reg != '0)
                        begin
                            volume_next = volume_reg - 1'b1;
                            if (volume_reg == VOL_W'(1))
                            begin
                                env_run_next = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        env_count_next = env_count_reg - 1'b1;
                    end
                end
            end
            OP_WRITE:
            begin
                unique case (item.reg_sel)
                    REG_LENGTH:
                    begin
                        length_next = LEN_FULL - {1'b0, wd[5:0]};
                    end
                    REG_ENVELOPE:
                    begin
                        env_period_next = wd[2:0];
                        env_count_next  = wd[2:0];
                        env_up_next     = wd[3];
                        env_start_next  = wd[7:4];
                        if (wd[7:3] == '0)
                        begin
                            enabled_next = 1'b0;
                        end
                    end
                    REG_POLY:
                    begin
                        divisor_next = wd[2:0];
                        short_next   = wd[3];
                        shift_next   = wd[7:4];
                    end
                    REG_CONTROL:
                    begin
                        len_en_next = wd[LEN_EN_BIT];
                        if (wd[TRIGGER_BIT])
                        begin
                            div_count_next = '0;
                            lfsr_next      = LFSR_ALL_ONES;
                            if (length_reg == '0)
                            begin
                                length_next = LEN_FULL;
                            end
                            env_count_next = env_period_reg;
                            volume_next    = env_start_reg;
                            env_run_next   = 1'b1;
                            if (env_start_reg != '0 || env_up_reg)
                            begin
                                enabled_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg       <= LFSR_ALL_ONES;
            div_count_reg  <= '0;
            divisor_reg    <= '0;
            shift_reg      <= '0;
            short_reg      <= 1'b0;
            length_reg     <= '0;
            len_en_reg     <= 1'b0;
            env_period_reg <= '0;
            env_count_reg  <= '0;
            env_up_reg     <= 1'b0;
            env_start_reg  <= '0;
            volume_reg     <= '0;
            env_run_reg    <= 1'b0;
            enabled_reg    <= 1'b0;
        end
        else if (fire)
        begin
            lfsr_reg       <= lfsr_next;
            div_count_reg  <= div_count_next;
            divisor_reg    <= divisor_next;
            shift_reg      <= shift_next;
            short_reg      <= short_next;
            length_reg     <= length_next;
            len_en_reg     <= len_en_next;
            env_period_reg <= env_period_next;
            env_count_reg  <= env_count_next;
            env_up_reg     <= env_up_next;
            env_start_reg  <= env_start_next;
            volume_reg     <= volume_next;
            env_run_reg    <= env_run_next;
            enabled_reg    <= enabled_next;
        end
    end

    // The result reflects the state after this item.
    assign result.sample     = (enabled_next && !lfsr_next[0]) ? volume_next : '0;
    assign result.channel_on = enabled_next;
endmodule

// File: src/lnc_output_stage.sv
module lnc_output_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    output logic                 can_load,
    input  lnc_pkg::lnc_result_t result,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lnc_pkg::lnc_result_t out_result
);
    import lnc_pkg::*;

    logic        valid_reg;
    lnc_result_t result_reg;

    assign can_load = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;
endmodule

// File: src/lnc_checker.sv
module lnc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // A muted channel never sounds.
    a_off_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[3:0] == 4'd0)
        else $error("sample nonzero while channel is off");

    // Input stalls only while a result waits on a stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:5] == 3'd0)
        else $error("result padding not zero");

endmodule

bind lfsr_noise_channel lnc_checker u_lnc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import lnc_pkg::*;

    // A stall of this many cycles in a row with no item moving on either side ends the run.
    // The longest correct stall is the long receiver hold-off.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int ITEMS_PER_PHASE = 370;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [3:0] s_axis_tuser = '0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    lfsr_noise_channel uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Items waiting to be offered, and the sample/flag pairs expected back, oldest first.
    lnc_item_t   pending_items[$];
    lnc_result_t expected_samples[$];

    // Idle percentages for the two sides; changed between phases only.
    int snd_idle_pct = 12;
    int rcv_idle_pct = 75;
    bit hold_req = 1'b0;

    int err_count = 0;
    int results_checked = 0;
    int results_on = 0;
    int op_seen[4] = '{0, 0, 0, 0};
    int stall_cycles = 0;
    bit in_fire = 1'b0;
    bit out_fire = 1'b0;

    // Private copy of the channel state, updated once per accepted item.
    logic [LFSR_W-1:0] nz_lfsr;
    logic [DIV_W-1:0]  div_cnt;
    logic [2:0]        div_code;
    logic [3:0]        div_shift;
    logic              short_lfsr;
    logic [LEN_W-1:0]  len_left;
    logic              len_en;
    logic [2:0]        env_per;
    logic [2:0]        env_cnt;
    logic              env_dir_up;
    logic [VOL_W-1:0]  env_init_vol;
    logic [VOL_W-1:0]  cur_vol;
    logic              env_active;
    logic              chan_on;

    // Base divider period: 8 for code zero, otherwise sixteen times the code.
    function automatic logic [6:0] noise_base(input logic [2:0] code);
        return (code == 3'd0) ? 7'd8 : {code, 4'd0};
    endfunction

    // One shift of the noise register. The feedback is the XOR of the two low bits and
    // enters at the top; in short mode it is copied into bit 6 as well.
    function automatic logic [LFSR_W-1:0] noise_shift(input logic [LFSR_W-1:0] cur);
        logic              fb;
        logic [LFSR_W-1:0] nxt;
        fb  = cur[0] ^ cur[1];
        nxt = {fb, cur[LFSR_W-1:1]};
        if (short_lfsr)
        begin
            nxt[6] = fb;
        end
        return nxt;
    endfunction

    // Applies one item to the private state and returns the sample/flag pair it yields.
    function automatic lnc_result_t predict_noise(input lnc_item_t it);
        lnc_result_t res;
        logic [20:0] per;
        logic [20:0] acc;
        logic [7:0]  d;
        d = it.write_data;
        case (it.op)
            OP_CYCLES:
            begin
                // The divider holds while the channel is off or the shift is too large.
                if (chan_on && div_shift < SHIFT_LIMIT)
                begin
                    per = {14'd0, noise_base(div_code)} << div_shift;
                    acc = {1'b0, div_cnt} + {17'd0, it.cycle_count};
                    if (acc >= per)
                    begin
                        nz_lfsr = noise_shift(nz_lfsr);
                        acc = acc - per;
                    end
                    if (acc >= per)
                    begin
                        nz_lfsr = noise_shift(nz_lfsr);
                        acc = acc - per;
                    end
                    // Only reachable after the period was shortened under a large count.
                    if (acc >= per)
                    begin
                        acc = '0;
                    end
                    div_cnt = acc[DIV_W-1:0];
                end
            end
            OP_LENGTH:
            begin
                // The length counter runs whether or not the channel is on.
                if (len_en && len_left != '0)
                begin
                    len_left = len_left - 1'b1;
                    if (len_left == '0)
                    begin
                        chan_on = 1'b0;
                    end
                end
            end
            OP_ENVELOPE:
            begin
                if (chan_on && env_active && env_per != 3'd0)
                begin
                    if (env_cnt <= 3'd1)
                    begin
                        if (env_dir_up)
                        begin
                            if (cur_vol < VOL_MAX)
                            begin
                                cur_vol = cur_vol + 1'b1;
                                if (cur_vol == VOL_MAX)
                                begin
                                    env_active = 1'b0;
                                end
                            end
                        end
                        else if (cur_vol > '0)
                        begin
                            cur_vol = cur_vol - 1'b1;
                            if (cur_vol == '0)
                            begin
                                env_active = 1'b0;
                            end
                        end
                        env_cnt = env_per;
                    end
                    else
                    begin
                        env_cnt = env_cnt - 1'b1;
                    end
                end
            end
            default:
            begin
                case (it.reg_sel)
                    REG_LENGTH:
                    begin
                        len_left = LEN_FULL - {1'b0, d[5:0]};
                    end
                    REG_ENVELOPE:
                    begin
                        env_per      = d[2:0];
                        env_cnt      = d[2:0];
                        env_dir_up   = d[3];
                        env_init_vol = d[7:4];
                        // The DAC is off when start volume is zero and the direction is down.
                        if (d[7:3] == 5'd0)
                        begin
                            chan_on = 1'b0;
                        end
                    end
                    REG_POLY:
                    begin
                        div_code   = d[2:0];
                        short_lfsr = d[3];
                        div_shift  = d[7:4];
                    end
                    default:
                    begin
                        len_en = d[LEN_EN_BIT];
                        if (d[TRIGGER_BIT])
                        begin
                            div_cnt = '0;
                            nz_lfsr = LFSR_ALL_ONES;
                            if (len_left == '0)
                            begin
                                len_left = LEN_FULL;
                            end
                            env_cnt    = env_per;
                            cur_vol    = env_init_vol;
                            env_active = 1'b1;
                            if (env_init_vol != '0 || env_dir_up)
                            begin
                                chan_on = 1'b1;
                            end
                        end
                    end
                endcase
            end
        endcase
        res.sample     = (chan_on && !nz_lfsr[0]) ? cur_vol : '0;
        res.channel_on = chan_on;
        return res;
    endfunction

    task automatic queue_item(input lnc_op_t op, input logic [3:0] cc,
                              input lnc_reg_sel_t sel, input logic [7:0] data);
        lnc_item_t it;
        it.op          = op;
        it.cycle_count = cc;
        it.reg_sel     = sel;
        it.write_data  = data;
        pending_items.push_back(it);
    endtask

    // Mostly complete note setups (envelope, polynomial, length, trigger) followed by
    // a burst of clock items, with short runs of fully random items mixed in.
    task automatic queue_random_traffic(input int count);
        int         added;
        int         burst;
        int         r;
        logic [3:0] shift;
        logic [7:0] env_byte;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(99) < 80)
            begin
                // Keep the DAC on most of the time so the channel actually plays.
                env_byte = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                    : 8'($urandom_range(8, 255));
                queue_item(OP_WRITE, 4'($urandom_range(15)), REG_ENVELOPE, env_byte);
                // Small shifts let the shift register step often; large ones are rarer.
                shift = ($urandom_range(15) < 12) ? 4'($urandom_range(2))
                                                  : 4'($urandom_range(3, 15));
                queue_item(OP_WRITE, 4'($urandom_range(15)), REG_POLY,
                           {shift, 1'($urandom_range(1)), 3'($urandom_range(7))});
                added += 2;
                if ($urandom_range(9) < 7)
                begin
                    queue_item(OP_WRITE, 4'($urandom_range(15)), REG_LENGTH,
                               8'($urandom_range(255)));
                    added++;
                end
                queue_item(OP_WRITE, 4'($urandom_range(15)), REG_CONTROL,
                           {1'b1, 7'($urandom_range(127))});
                added++;
                burst = $urandom_range(8, 40);
                repeat (burst)
                begin
                    r = $urandom_range(99);
                    if (r < 70)
                    begin
                        queue_item(OP_CYCLES, 4'($urandom_range(15)), 2'($urandom_range(3)),
                                   8'($urandom_range(255)));
                    end
                    else if (r < 82)
                    begin
                        queue_item(OP_LENGTH, 4'($urandom_range(15)), 2'($urandom_range(3)),
                                   8'($urandom_range(255)));
                    end
                    else if (r < 94)
                    begin
                        queue_item(OP_ENVELOPE, 4'($urandom_range(15)),
                                   2'($urandom_range(3)), 8'($urandom_range(255)));
                    end
                    else
                    begin
                        queue_item(OP_WRITE, 4'($urandom_range(15)), 2'($urandom_range(3)),
                                   8'($urandom_range(255)));
                    end
                end
                added += burst;
            end
            else
            begin
                burst = $urandom_range(1, 5);
                repeat (burst)
                begin
                    queue_item(2'($urandom_range(3)), 4'($urandom_range(15)),
                               2'($urandom_range(3)), 8'($urandom_range(255)));
                end
                added += burst;
            end
        end
    endtask

    // Blocks until the sender has nothing left and every expected result has come back.
    task automatic wait_drained;
        while (pending_items.size() != 0 || expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Sender: a new item may be offered once the previous one was taken; an offered item
    // is held until the block accepts it.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (s_axis_tvalid && !in_fire)
        begin
            s_axis_tvalid <= 1'b1;
        end
        else if (pending_items.size() != 0 && $urandom_range(99) >= snd_idle_pct)
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {4'd0, pending_items[0].write_data, pending_items[0].cycle_count};
            s_axis_tuser  <= {pending_items[0].reg_sel, pending_items[0].op};
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request so that the
    // block fills up and has to stall its input.
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Rising edge: check any result against the oldest expectation first, then predict
    // from any accepted item. Results trail inputs through the input and result registers,
    // so the order of the two within one edge does not matter.
    always @(posedge clk)
    begin
        lnc_item_t   in_item;
        lnc_result_t want;
        in_fire  = 1'b0;
        out_fire = 1'b0;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                out_fire = 1'b1;
                if (expected_samples.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("unexpected result: sample %0d channel_on %0b",
                                 m_axis_tdata[3:0], m_axis_tdata[4]);
                    end
                end
                else
                begin
                    want = expected_samples.pop_front();
                    results_checked++;
                    if (want.channel_on)
                    begin
                        results_on++;
                    end
                    if (m_axis_tdata[3:0] !== want.sample
                        || m_axis_tdata[4] !== want.channel_on)
                    begin
                        err_count++;
                        if (err_count <= 10)
                        begin
                            $display("result %0d: expected sample %0d on %0b, got %0d on %0b",
                                     results_checked, want.sample, want.channel_on,
                                     m_axis_tdata[3:0], m_axis_tdata[4]);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_fire = 1'b1;
                in_item.op          = s_axis_tuser[1:0];
                in_item.reg_sel     = s_axis_tuser[3:2];
                in_item.cycle_count = s_axis_tdata[3:0];
                in_item.write_data  = s_axis_tdata[11:4];
                op_seen[in_item.op]++;
                expected_samples.push_back(predict_noise(in_item));
                void'(pending_items.pop_front());
            end
            if (in_fire || out_fire)
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        // Predicted state after reset.
        nz_lfsr      = LFSR_ALL_ONES;
        div_cnt      = '0;
        div_code     = '0;
        div_shift    = '0;
        short_lfsr   = 1'b0;
        len_left     = '0;
        len_en       = 1'b0;
        env_per      = '0;
        env_cnt      = '0;
        env_dir_up   = 1'b0;
        env_init_vol = '0;
        cur_vol      = '0;
        env_active   = 1'b0;
        chan_on      = 1'b0;

        // Directed items. Clocks of every kind right after reset, with the channel off, do nothing.
        queue_item(OP_CYCLES,   4'd15, REG_LENGTH, 8'h00);
        queue_item(OP_ENVELOPE, 4'd0,  REG_LENGTH, 8'h00);
        queue_item(OP_LENGTH,   4'd0,  REG_LENGTH, 8'h00);
        // A trigger with the DAC off leaves the channel disabled.
        queue_item(OP_WRITE, 4'd0, REG_ENVELOPE, 8'h00);
        queue_item(OP_WRITE, 4'd0, REG_CONTROL,  8'h80);
        // Full volume, period 32, one length step left, then trigger with length on.
        queue_item(OP_WRITE, 4'd0, REG_ENVELOPE, 8'hF0);
        queue_item(OP_WRITE, 4'd0, REG_POLY,     8'h02);
        queue_item(OP_WRITE, 4'd0, REG_LENGTH,   8'h3F);
        queue_item(OP_WRITE, 4'd0, REG_CONTROL,  8'hC0);
        queue_item(OP_CYCLES, 4'd15, REG_LENGTH, 8'h00);
        queue_item(OP_CYCLES, 4'd15, REG_LENGTH, 8'h00);
        // Shortening the period under a large count: two steps, then the count clears.
        queue_item(OP_WRITE,  4'd0, REG_POLY,    8'h00);
        queue_item(OP_CYCLES, 4'd0, REG_LENGTH,  8'h00);
        queue_item(OP_CYCLES, 4'd8, REG_LENGTH,  8'h00);
        // The last length step switches the channel off.
        queue_item(OP_LENGTH, 4'd0, REG_LENGTH,  8'h00);
        // Rising envelope from zero keeps the DAC on; largest shift in short mode.
        queue_item(OP_WRITE, 4'd0, REG_ENVELOPE, 8'h0B);
        queue_item(OP_WRITE, 4'd0, REG_POLY,     8'hF8);
        queue_item(OP_WRITE, 4'd0, REG_CONTROL,  8'hBF);
        queue_item(OP_CYCLES, 4'd15, REG_LENGTH, 8'h00);
        repeat (3)
        begin
            queue_item(OP_ENVELOPE, 4'd0, REG_LENGTH, 8'h00);
        end
        // Shift of 13 is the largest one that still clocks.
        queue_item(OP_WRITE,  4'd0,  REG_POLY,   8'hD7);
        queue_item(OP_CYCLES, 4'd15, REG_LENGTH, 8'h00);
        // Turning the DAC off while playing disables the channel.
        queue_item(OP_WRITE, 4'd0, REG_ENVELOPE, 8'h07);
        queue_item(OP_WRITE, 4'd0, REG_LENGTH,   8'hFF);
        queue_item(OP_WRITE, 4'd0, REG_CONTROL,  8'hFF);

        // Phase one: sender idles a little, receiver a lot.
        queue_random_traffic(ITEMS_PER_PHASE);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait_drained();
        // Phase two: the other way round.
        snd_idle_pct = 75;
        rcv_idle_pct = 12;
        queue_random_traffic(ITEMS_PER_PHASE);
        wait_drained();
        // Phase three: no idling, and one long receiver hold-off while items keep coming.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req     = 1'b1;
        queue_random_traffic(ITEMS_PER_PHASE);
        wait_drained();

        repeat (10) @(posedge clk);
        if (expected_samples.size() != 0)
        begin
            err_count++;
        end
        $display("items: %0d cycle batches, %0d length clocks, %0d envelope clocks, %0d writes",
                 op_seen[OP_CYCLES], op_seen[OP_LENGTH], op_seen[OP_ENVELOPE], op_seen[OP_WRITE]);
        $display("results checked: %0d (%0d with channel on), mismatches: %0d",
                 results_checked, results_on, err_count);
        if (err_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/lnc_pkg.sv
src/lnc_input_stage.sv
src/lnc_core.sv
src/lnc_output_stage.sv
src/lfsr_noise_channel.sv
src/lnc_checker.sv
sim/testbench.sv
